// File: design/pldt_pkg.sv
// Package with shared types and constants of the path loss degradation tracker.
`timescale 1ns / 1ps

package pldt_pkg;

  localparam int unsigned CWND_W  = 32;
  localparam int unsigned TX_W    = 48;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned PATH_W  = 4;
  localparam int unsigned QUO_W   = 22;
  localparam int unsigned ENTRY_W = TX_W + CNT_W;

  localparam logic [CWND_W-1:0] PKT_BYTES          = 32'd1200;
  localparam logic [CWND_W-1:0] DEFAULT_CWND_BYTES = 32'd12000;
  localparam logic [QUO_W-1:0]  MIN_ROUND_PKTS     = 22'd10;
  localparam logic [THR_W-1:0]  DEFAULT_THRESHOLD  = 8'd5;
  localparam logic [CNT_W-1:0]  CNT_MAX            = 8'hFF;

  // floor(2^42 / 1200): the estimate is the true quotient or one below it.
  localparam logic [CWND_W-1:0] RECIP       = 32'd3665038759;
  localparam int unsigned       RECIP_SHIFT = 42;

  localparam logic ACT_ACK  = 1'b0;
  localparam logic ACT_LOSS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_QUO,
    ST_UPD
  } pldt_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic quo;
    logic upd;
  } pldt_cmd_t;

  typedef struct packed {
    logic out_free;
  } pldt_sts_t;

endpackage

// File: design/path_loss_degradation_tracker_core.sv
// Top level of the path loss degradation tracker.
//
//   Channel  Ports                          Moves
//   in       in_valid / in_ready           one event transaction
//   out      out_valid / out_ready         one result transaction per event
//   cfg      cfg_wr_en / cfg_wr_data       degradation threshold write
//
// Each transaction passes through four steps: accept and table read, reciprocal
// multiply, quotient correction, then table write and result register load.
// The registered table read and the reciprocal division, split into multiply and correction, set those steps.
// Reset clears the table valid bits at once, so no clearing pass is needed.
// A held result stalls the final step, and no new event is accepted until that step completes.
`timescale 1ns / 1ps

module path_loss_degradation_tracker_core #(
  parameter int unsigned PATH_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_path_index,
  input  logic [31:0] in_cwnd_bytes,
  input  logic [47:0] in_tx_packet_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_path_failed,
  output logic        out_round_restarted,
  output logic [7:0]  out_losses_in_round,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  pldt_pkg::pldt_cmd_t cmd;
  pldt_pkg::pldt_sts_t sts;

  pldt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  pldt_dp #(
    .PATH_COUNT(PATH_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_path_index      (in_path_index),
    .in_cwnd_bytes      (in_cwnd_bytes),
    .in_tx_packet_count (in_tx_packet_count),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_path_failed    (out_path_failed),
    .out_round_restarted(out_round_restarted),
    .out_losses_in_round(out_losses_in_round)
  );

endmodule

// File: design/pldt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pldt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/pldt_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
`timescale 1ns / 1ps

module pldt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pldt_pkg::pldt_sts_t sts,
  output pldt_pkg::pldt_cmd_t cmd
);

  pldt_pkg::pldt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pldt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pldt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = pldt_pkg::ST_MUL;
        end
      end
      pldt_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = pldt_pkg::ST_QUO;
      end
      pldt_pkg::ST_QUO: begin
        cmd.quo   = 1'b1;
        state_nxt = pldt_pkg::ST_UPD;
      end
      pldt_pkg::ST_UPD: begin
        if (sts.out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = pldt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pldt_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/pldt_dp.sv
// Datapath with the per-path table, round sizing arithmetic and result register.
`timescale 1ns / 1ps

module pldt_dp #(
  parameter int unsigned PATH_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pldt_pkg::pldt_cmd_t                 cmd,
  output pldt_pkg::pldt_sts_t                 sts,
  input  logic                                in_action,
  input  logic [pldt_pkg::PATH_W-1:0]         in_path_index,
  input  logic [pldt_pkg::CWND_W-1:0]         in_cwnd_bytes,
  input  logic [pldt_pkg::TX_W-1:0]           in_tx_packet_count,
  input  logic                                cfg_wr_en,
  input  logic [pldt_pkg::THR_W-1:0]          cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_path_failed,
  output logic                                out_round_restarted,
  output logic [pldt_pkg::CNT_W-1:0]          out_losses_in_round
);

  localparam int unsigned AW = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;

  localparam int unsigned CW = pldt_pkg::CWND_W;
  localparam int unsigned TW = pldt_pkg::TX_W;
  localparam int unsigned NW = pldt_pkg::CNT_W;
  localparam int unsigned QW = pldt_pkg::QUO_W;
  localparam int unsigned EW = pldt_pkg::ENTRY_W;

  logic [pldt_pkg::THR_W-1:0] thr_r;
  logic [PATH_COUNT-1:0]      valid_r;
  logic                       act_r;
  logic                       in_range_r;
  logic                       entry_valid_r;
  logic [AW-1:0]              addr_r;
  logic [CW-1:0]              win_r;
  logic [TW-1:0]              tx_r;
  logic [2*CW-1:0]            prod_r;
  logic [QW-1:0]              pkts_r;
  logic                       out_valid_r;
  logic                       out_failed_r;
  logic                       out_restarted_r;
  logic [NW-1:0]              out_losses_r;

  logic [AW-1:0] in_addr;
  logic          in_range;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  assign in_addr  = AW'(in_path_index);
  assign in_range = (32'(in_path_index) < 32'(PATH_COUNT));

  pldt_ram #(
    .WIDTH(EW),
    .DEPTH(PATH_COUNT),
    .AW   (AW)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(addr_r),
    .wr_data(wr_data),
    .rd_en  (cmd.load),
    .rd_addr(in_addr),
    .rd_data(rd_data)
  );

  // Quotient estimate and its one-step correction.
  logic [QW-1:0] q_est;
  logic [CW-1:0] q_prod;
  logic [CW-1:0] q_rem;
  logic [QW-1:0] q_fix;
  logic [QW-1:0] pkts_nxt;

  always_comb begin
    q_est    = prod_r[pldt_pkg::RECIP_SHIFT +: QW];
    q_prod   = CW'(q_est) * pldt_pkg::PKT_BYTES;
    q_rem    = win_r - q_prod;
    q_fix    = (q_rem >= pldt_pkg::PKT_BYTES) ? q_est + QW'(1) : q_est;
    pkts_nxt = (q_fix == '0) ? pldt_pkg::MIN_ROUND_PKTS : q_fix;
  end

  // Update of the entry and the result.
  logic [TW-1:0]              rs_old;
  logic [NW-1:0]              lc_old;
  logic [TW:0]                round_end;
  logic                       restart;
  logic [NW-1:0]              lc_base;
  logic [NW-1:0]              cnt;
  logic [pldt_pkg::THR_W-1:0] thr_eff;
  logic                       fail;
  logic [NW-1:0]              lc_new;
  logic [TW-1:0]              rs_new;
  logic                       res_failed;
  logic                       res_restarted;
  logic [NW-1:0]              res_losses;

  always_comb begin
    rs_old    = entry_valid_r ? rd_data[EW-1:NW] : '0;
    lc_old    = entry_valid_r ? rd_data[NW-1:0] : '0;
    round_end = (TW+1)'(rs_old) + (TW+1)'(pkts_r);
    restart   = ((TW+1)'(tx_r) > round_end);
    lc_base   = restart ? '0 : lc_old;
    cnt       = (lc_base == pldt_pkg::CNT_MAX) ? pldt_pkg::CNT_MAX : lc_base + NW'(1);
    thr_eff   = (thr_r == '0) ? pldt_pkg::DEFAULT_THRESHOLD : thr_r;
    fail      = (cnt >= thr_eff);
    if (act_r == pldt_pkg::ACT_LOSS) begin
      lc_new        = fail ? '0 : cnt;
      rs_new        = restart ? tx_r : rs_old;
      res_failed    = fail;
      res_restarted = restart;
      res_losses    = cnt;
    end else begin
      lc_new        = '0;
      rs_new        = rs_old;
      res_failed    = 1'b0;
      res_restarted = 1'b0;
      res_losses    = '0;
    end
    if (!in_range_r) begin
      res_failed    = 1'b0;
      res_restarted = 1'b0;
      res_losses    = '0;
    end
    wr_en   = cmd.upd && in_range_r;
    wr_data = {rs_new, lc_new};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= pldt_pkg::DEFAULT_THRESHOLD;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (wr_en) begin
        valid_r[addr_r] <= 1'b1;
      end
      if (cmd.upd) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r         <= in_action;
      addr_r        <= in_addr;
      in_range_r    <= in_range;
      entry_valid_r <= in_range && valid_r[in_addr];
      win_r         <= (in_cwnd_bytes == '0) ? pldt_pkg::DEFAULT_CWND_BYTES : in_cwnd_bytes;
      tx_r          <= in_tx_packet_count;
    end
    if (cmd.mul) begin
      prod_r <= (2*CW)'(win_r) * (2*CW)'(pldt_pkg::RECIP);
    end
    if (cmd.quo) begin
      pkts_r <= pkts_nxt;
    end
    if (cmd.upd) begin
      out_failed_r    <= res_failed;
      out_restarted_r <= res_restarted;
      out_losses_r    <= res_losses;
    end
  end

  assign sts.out_free        = !out_valid_r || out_ready;
  assign out_valid           = out_valid_r;
  assign out_path_failed     = out_failed_r;
  assign out_round_restarted = out_restarted_r;
  assign out_losses_in_round = out_losses_r;

endmodule

// File: test/path_loss_degradation_tracker_core_tb.sv
// Self-checking testbench for the path loss degradation tracker core.
`timescale 1ns / 1ps

module path_loss_degradation_tracker_core_tb;

  localparam int unsigned PATHS = 16;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned MAX_GAP = 18;

  typedef struct packed {
    logic        action;
    logic [3:0]  path_index;
    logic [31:0] cwnd_bytes;
    logic [47:0] tx_packet_count;
  } loss_event_t;

  typedef struct packed {
    logic       path_failed;
    logic       round_restarted;
    logic [7:0] losses_in_round;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = pldt_pkg::ACT_ACK;
  logic [3:0]  in_path_index = '0;
  logic [31:0] in_cwnd_bytes = '0;
  logic [47:0] in_tx_packet_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_path_failed;
  logic        out_round_restarted;
  logic [7:0]  out_losses_in_round;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  loss_event_t pending_events[$];
  verdict_t    expected_verdicts[$];

  logic [7:0]  threshold_shadow;
  logic [7:0]  loss_count [PATHS];
  logic [47:0] round_begin [PATHS];
  logic [47:0] tx_cursor [PATHS];

  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  logic        sender_calm = 1'b0;
  logic        receiver_calm = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  int unsigned n_acks = 0;
  int unsigned n_losses = 0;
  int unsigned n_failures = 0;
  int unsigned n_restarts = 0;
  int unsigned peak_losses = 0;

  path_loss_degradation_tracker_core #(
    .PATH_COUNT(PATHS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_path_index      (in_path_index),
    .in_cwnd_bytes      (in_cwnd_bytes),
    .in_tx_packet_count (in_tx_packet_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_path_failed    (out_path_failed),
    .out_round_restarted(out_round_restarted),
    .out_losses_in_round(out_losses_in_round),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic verdict_t track_event(loss_event_t ev);
    verdict_t    v;
    logic [31:0] win;
    logic [31:0] pkts;
    int unsigned thr;
    int unsigned cnt;
    v = '0;
    if (ev.action == pldt_pkg::ACT_ACK) begin
      loss_count[ev.path_index] = '0;
      n_acks++;
    end else begin
      n_losses++;
      win = (ev.cwnd_bytes == '0) ? pldt_pkg::DEFAULT_CWND_BYTES : ev.cwnd_bytes;
      pkts = win / pldt_pkg::PKT_BYTES;
      if (pkts == '0) begin
        pkts = 32'(pldt_pkg::MIN_ROUND_PKTS);
      end
      thr = (threshold_shadow == '0) ? int'(pldt_pkg::DEFAULT_THRESHOLD)
                                     : int'(threshold_shadow);
      if (64'(ev.tx_packet_count) > 64'(round_begin[ev.path_index]) + 64'(pkts)) begin
        loss_count[ev.path_index] = '0;
        round_begin[ev.path_index] = ev.tx_packet_count;
        v.round_restarted = 1'b1;
        n_restarts++;
      end
      cnt = int'(loss_count[ev.path_index]) + 1;
      if (cnt > 255) begin
        cnt = 255;
      end
      v.losses_in_round = cnt[7:0];
      if (cnt > peak_losses) begin
        peak_losses = cnt;
      end
      if (cnt >= thr) begin
        v.path_failed = 1'b1;
        n_failures++;
        cnt = 0;
      end
      loss_count[ev.path_index] = cnt[7:0];
    end
    return v;
  endfunction

  function automatic loss_event_t make_random_event();
    loss_event_t ev;
    int unsigned r;
    int unsigned k;
    logic [63:0] wide;
    r = $urandom_range(0, 99);
    ev.path_index = (r < 70) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    ev.action = ($urandom_range(0, 3) == 0) ? pldt_pkg::ACT_ACK : pldt_pkg::ACT_LOSS;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      ev.cwnd_bytes = '0;
    end else if (r < 15) begin
      ev.cwnd_bytes = $urandom_range(1, 1199);
    end else if (r < 55) begin
      k = $urandom_range(1, 20);
      ev.cwnd_bytes = k * 1200 - $urandom_range(0, 1);
    end else if (r < 70) begin
      k = $urandom_range(1, 3579139);
      ev.cwnd_bytes = k * 1200 - $urandom_range(0, 1);
    end else if (r < 95) begin
      ev.cwnd_bytes = $urandom;
    end else begin
      ev.cwnd_bytes = 32'hFFFF_FFFF;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      tx_cursor[ev.path_index] += 48'($urandom_range(0, 3));
    end else if (r < 90) begin
      tx_cursor[ev.path_index] += 48'($urandom_range(4, 30));
    end else if (r < 98) begin
      tx_cursor[ev.path_index] += 48'($urandom_range(31, 1 << 20));
    end else begin
      wide = {$urandom, $urandom};
      tx_cursor[ev.path_index] = wide[47:0];
    end
    ev.tx_packet_count = tx_cursor[ev.path_index];
    return ev;
  endfunction

  task automatic add_event(logic act, logic [3:0] path, logic [31:0] cwnd, logic [47:0] tx);
    loss_event_t ev;
    ev.action = act;
    ev.path_index = path;
    ev.cwnd_bytes = cwnd;
    ev.tx_packet_count = tx;
    pending_events.push_back(ev);
  endtask

  task automatic add_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      pending_events.push_back(make_random_event());
    end
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    threshold_shadow = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Sender: predicts each accepted transaction and presents the next pending one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(track_event({in_action, in_path_index, in_cwnd_bytes,
                                                 in_tx_packet_count}));
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_events.size() != 0) begin
          {in_action, in_path_index, in_cwnd_bytes, in_tx_packet_count}
            <= pending_events.pop_front();
          in_valid <= 1'b1;
          send_gap <= sender_calm ? 0 : $urandom_range(0, MAX_GAP);
          if ($urandom_range(0, 39) == 0) begin
            sender_calm <= !sender_calm;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and stalls at random between them.
  always @(posedge clk) begin
    verdict_t    exp_v;
    int unsigned stall_draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected, actual failed %0b restarted %0b losses %0d",
                 $time, out_path_failed, out_round_restarted, out_losses_in_round);
        error_count++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        compare_field("path_failed", exp_v.path_failed, out_path_failed);
        compare_field("round_restarted", exp_v.round_restarted, out_round_restarted);
        compare_field("losses_in_round", exp_v.losses_in_round, out_losses_in_round);
      end
      stall_draw = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
      out_ready <= (stall_draw == 0);
      recv_stall <= stall_draw;
      if ($urandom_range(0, 39) == 0) begin
        receiver_calm <= !receiver_calm;
      end
    end else if (!out_ready) begin
      if (recv_stall <= 1) begin
        out_ready <= 1'b1;
        recv_stall <= 0;
      end else begin
        recv_stall <= recv_stall - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    threshold_shadow = pldt_pkg::DEFAULT_THRESHOLD;
    for (int p = 0; p < PATHS; p++) begin
      loss_count[p] = '0;
      round_begin[p] = '0;
      tx_cursor[p] = (p >= 12) ? 48'hFFFF_FFFF_FFC0 : 48'(p * 1000);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Round sizing edges, restart boundaries and the threshold at its default.
    add_event(pldt_pkg::ACT_ACK, 4'd0, 32'd0, 48'd0);
    add_event(pldt_pkg::ACT_LOSS, 4'd0, 32'd0, 48'd10);
    add_event(pldt_pkg::ACT_LOSS, 4'd0, 32'd0, 48'd11);
    add_event(pldt_pkg::ACT_LOSS, 4'd1, 32'd1199, 48'd10);
    add_event(pldt_pkg::ACT_LOSS, 4'd1, 32'd1200, 48'd2);
    add_event(pldt_pkg::ACT_LOSS, 4'd1, 32'd2399, 48'd3);
    add_event(pldt_pkg::ACT_LOSS, 4'd1, 32'd2400, 48'd4);
    add_event(pldt_pkg::ACT_LOSS, 4'd1, 32'hFFFF_FFFF, 48'd4);
    add_event(pldt_pkg::ACT_LOSS, 4'd1, 32'hFFFF_FFFF, 48'd4);
    add_event(pldt_pkg::ACT_LOSS, 4'd1, 32'd1, 48'd4);
    add_event(pldt_pkg::ACT_LOSS, 4'd15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_event(pldt_pkg::ACT_LOSS, 4'd15, 32'hFFFF_FFFF, 48'd0);
    add_event(pldt_pkg::ACT_ACK, 4'd15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_event(pldt_pkg::ACT_LOSS, 4'd15, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
    add_event(pldt_pkg::ACT_LOSS, 4'd2, 32'd4294966800, 48'd3579139);
    add_event(pldt_pkg::ACT_LOSS, 4'd2, 32'd4294966800, 48'd3579140);
    add_event(pldt_pkg::ACT_LOSS, 4'd2, 32'd4294966799, 48'd7158278);
    add_event(pldt_pkg::ACT_LOSS, 4'd2, 32'd4294966799, 48'd7158279);
    add_event(pldt_pkg::ACT_LOSS, 4'd10, 32'h5555_5555, 48'hAAAA_AAAA_AAAA);
    add_event(pldt_pkg::ACT_LOSS, 4'd5, 32'hAAAA_AAAA, 48'h5555_5555_5555);
    drain();

    write_threshold(8'd0);
    add_random(200);
    drain();

    write_threshold(8'd1);
    add_random(150);
    drain();

    // One long round on a single path so the count climbs to the top threshold.
    write_threshold(8'd255);
    add_event(pldt_pkg::ACT_LOSS, 4'd3, 32'd0, 48'hFFFF_FFFF_FFFF);
    for (int n = 0; n < 270; n++) begin
      add_event(pldt_pkg::ACT_LOSS, 4'd3, $urandom_range(12000, 32'hFFFF_FFFF),
                48'hFFFF_FFFF_FFFF);
    end
    add_random(80);
    drain();

    write_threshold(8'($urandom_range(2, 8)));
    add_random(250);
    drain();

    write_threshold(8'd3);
    add_random(250);
    drain();

    repeat (20) @(posedge clk);
    $display("Covered %0d acknowledgements and %0d losses over six threshold settings.",
             n_acks, n_losses);
    $display("Expected %0d path failures, %0d round restarts, peak loss count %0d.",
             n_failures, n_restarts, peak_losses);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
